>>> rtl/assert_macros.svh
// Assertion macros for the RTL of the directory lookup block.
// Included by files that carry concurrent checks; needs no other file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/fdl_pkg.sv
// Package of the flat directory lookup block: widths, codes and the
// request/response types of the shared geometry divider. Depends on nothing.
package fdl_pkg;

  localparam int DirBytesDef   = 512;
  localparam int EntryBytesDef = 32;
  localparam int NameBytesDef  = 6;

  localparam int IdxW     = 9;
  localparam int ByteW    = 8;
  localparam int NameInW  = 48;
  localparam int StatusW  = 2;
  localparam int ChunkW   = 5;
  localparam int SptW     = 6;
  localparam int HcW      = 2;
  localparam int CfgIdxW  = 4;
  localparam int CfgDataW = 8;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam logic [StatusW-1:0] ST_SECTOR    = 2'd0;
  localparam logic [StatusW-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [StatusW-1:0] ST_EMPTY     = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_SPT = 4'd0;
  localparam logic [CfgIdxW-1:0] REG_HC  = 4'd1;

  localparam logic [SptW-1:0] SPT_RESET = 6'd18;
  localparam logic [HcW-1:0]  HC_RESET  = 2'd2;

  typedef struct packed {
    logic             start;
    logic [ByteW-1:0] dividend;
  } chs_req_t;

  typedef struct packed {
    logic             done;
    logic [ByteW-1:0] track;
    logic             head;
    logic [SptW-1:0]  sit;
  } chs_rsp_t;

endpackage

>>> rtl/file_directory_lookup_top.sv
// Top level of the flat directory lookup block: configuration registers,
// sequencer, shared divider. Uses fdl_pkg, fdl_seq, fdl_chs, assert_macros.svh.
//
// Command channel: start with command, byte_index, byte_value, file_name;
// a word is taken on a rising edge with start high and busy low.
// A load word writes one directory byte; busy stays low.
// A lookup word raises busy until its last result has been sent.
// Name scan: a wait state and a compare state per compared byte, entries
// tried lowest first, up to NAME_BYTES bytes compared per directory entry.
// Each sector result waits for the eight-step shared divider, and a lookup
// gives up to 26 results.
// Results: result_valid marks each word for exactly one cycle; last marks
// the final word. The receiver cannot stall; every word must be taken.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; write
// only while busy is low. cfg_ready is always high.
// Reset: rst, synchronous; clears control state and loads the default
// geometry (18 sectors per track, 2 heads). Directory contents are
// undefined until loaded and need no clearing pass.
`include "assert_macros.svh"

module file_directory_lookup_top #(
  parameter int DIR_BYTES   = fdl_pkg::DirBytesDef,
  parameter int ENTRY_BYTES = fdl_pkg::EntryBytesDef,
  parameter int NAME_BYTES  = fdl_pkg::NameBytesDef
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          command,
  input  logic [fdl_pkg::IdxW-1:0]      byte_index,
  input  logic [fdl_pkg::ByteW-1:0]     byte_value,
  input  logic [fdl_pkg::NameInW-1:0]   file_name,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fdl_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [fdl_pkg::CfgDataW-1:0]  cfg_data,
  output logic                          result_valid,
  output logic [fdl_pkg::StatusW-1:0]   status,
  output logic [fdl_pkg::ByteW-1:0]     sector_number,
  output logic [fdl_pkg::ChunkW-1:0]    chunk_index,
  output logic [fdl_pkg::ByteW-1:0]     track,
  output logic                          head,
  output logic [fdl_pkg::SptW-1:0]      sector_in_track,
  output logic                          last
);

  logic [fdl_pkg::SptW-1:0] spt;
  logic [fdl_pkg::HcW-1:0]  hc;
  fdl_pkg::chs_req_t        chs_req;
  fdl_pkg::chs_rsp_t        chs_rsp;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      spt <= fdl_pkg::SPT_RESET;
      hc  <= fdl_pkg::HC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == fdl_pkg::REG_SPT) begin
        spt <= cfg_data[fdl_pkg::SptW-1:0];
      end else if (cfg_index == fdl_pkg::REG_HC) begin
        hc <= cfg_data[fdl_pkg::HcW-1:0];
      end
    end
  end

  fdl_seq #(
    .DIR_BYTES   (DIR_BYTES),
    .ENTRY_BYTES (ENTRY_BYTES),
    .NAME_BYTES  (NAME_BYTES)
  ) u_seq (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .command         (command),
    .byte_index      (byte_index),
    .byte_value      (byte_value),
    .file_name       (file_name),
    .busy            (busy),
    .chs_req         (chs_req),
    .chs_rsp         (chs_rsp),
    .result_valid    (result_valid),
    .status          (status),
    .sector_number   (sector_number),
    .chunk_index     (chunk_index),
    .track           (track),
    .head            (head),
    .sector_in_track (sector_in_track),
    .last            (last)
  );

  fdl_chs u_chs (
    .clk (clk),
    .rst (rst),
    .req (chs_req),
    .spt (spt),
    .hc  (hc),
    .rsp (chs_rsp)
  );

  `ASSERT_NEXT(a_lookup_busy, clk, rst, start && !busy && (command == fdl_pkg::CMD_LOOKUP), busy)
  `ASSERT_IMPLY(a_last_ends_busy, clk, rst, result_valid, busy == !last)
  `ASSERT_IMPLY(a_code_is_last, clk, rst, result_valid && (status != fdl_pkg::ST_SECTOR), last)
  `ASSERT_IMPLY(a_sector_nonzero, clk, rst, result_valid && (status == fdl_pkg::ST_SECTOR), (sector_number != '0) && (sector_in_track != '0))
  `ASSERT_IMPLY(a_one_head, clk, rst, result_valid && !hc[1], !head)

endmodule

>>> rtl/fdl_chs.sv
// Shared sector-to-track/head/sector unit: restoring divider, one quotient
// bit per cycle. Depends on fdl_pkg.
module fdl_chs (
  input  logic                      clk,
  input  logic                      rst,
  input  fdl_pkg::chs_req_t         req,
  input  logic [fdl_pkg::SptW-1:0]  spt,
  input  logic [fdl_pkg::HcW-1:0]   hc,
  output fdl_pkg::chs_rsp_t         rsp
);

  logic [fdl_pkg::ByteW-1:0] quo;
  logic [fdl_pkg::SptW-1:0]  rem;
  logic [2:0]                cnt;
  logic                      run;
  logic                      done;
  logic [fdl_pkg::SptW-1:0]  divisor;
  logic [fdl_pkg::SptW:0]    trial;
  logic [fdl_pkg::SptW:0]    diff;
  logic                      ge;

  assign divisor = (spt == '0) ? fdl_pkg::SptW'(1) : spt;
  assign trial   = {rem, quo[fdl_pkg::ByteW-1]};
  assign ge      = trial >= {1'b0, divisor};
  assign diff    = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      quo  <= '0;
      rem  <= '0;
    end else begin
      done <= run && (cnt == 3'd7);
      if (req.start) begin
        quo <= req.dividend;
        rem <= '0;
        cnt <= '0;
        run <= 1'b1;
      end else if (run) begin
        quo <= {quo[fdl_pkg::ByteW-2:0], ge};
        rem <= ge ? diff[fdl_pkg::SptW-1:0] : trial[fdl_pkg::SptW-1:0];
        cnt <= cnt + 3'd1;
        if (cnt == 3'd7) begin
          run <= 1'b0;
        end
      end
    end
  end

  // two heads whenever the head count is two or three
  assign rsp.done  = done;
  assign rsp.track = hc[1] ? {1'b0, quo[fdl_pkg::ByteW-1:1]} : quo;
  assign rsp.head  = hc[1] & quo[0];
  assign rsp.sit   = rem + fdl_pkg::SptW'(1);

endmodule

>>> rtl/fdl_seq.sv
// Directory store and lookup sequencer: byte-wide name scan, sector list walk,
// result formatting. Depends on fdl_pkg and drives the fdl_chs unit.
module fdl_seq #(
  parameter int DIR_BYTES   = fdl_pkg::DirBytesDef,
  parameter int ENTRY_BYTES = fdl_pkg::EntryBytesDef,
  parameter int NAME_BYTES  = fdl_pkg::NameBytesDef
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          command,
  input  logic [fdl_pkg::IdxW-1:0]      byte_index,
  input  logic [fdl_pkg::ByteW-1:0]     byte_value,
  input  logic [fdl_pkg::NameInW-1:0]   file_name,
  output logic                          busy,
  output fdl_pkg::chs_req_t             chs_req,
  input  fdl_pkg::chs_rsp_t             chs_rsp,
  output logic                          result_valid,
  output logic [fdl_pkg::StatusW-1:0]   status,
  output logic [fdl_pkg::ByteW-1:0]     sector_number,
  output logic [fdl_pkg::ChunkW-1:0]    chunk_index,
  output logic [fdl_pkg::ByteW-1:0]     track,
  output logic                          head,
  output logic [fdl_pkg::SptW-1:0]      sector_in_track,
  output logic                          last
);

  localparam int AddrW      = $clog2(DIR_BYTES);
  localparam int NumEntries = DIR_BYTES / ENTRY_BYTES;
  localparam int ListBytes  = ENTRY_BYTES - NAME_BYTES;
  localparam int EntW       = (NumEntries > 1) ? $clog2(NumEntries) : 1;
  localparam int NcW        = (NAME_BYTES > 1) ? $clog2(NAME_BYTES) : 1;
  localparam int KW         = (ListBytes > 1) ? $clog2(ListBytes) : 1;
  localparam int NameW      = 8 * NAME_BYTES;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_W,
    S_SCAN_C,
    S_LIST_W,
    S_LIST_C,
    S_DIV
  } state_t;

  state_t                    state;
  logic [fdl_pkg::ByteW-1:0] mem [DIR_BYTES];
  logic [fdl_pkg::ByteW-1:0] rdata;
  logic [AddrW-1:0]          ptr;
  logic [AddrW-1:0]          base;
  logic [EntW-1:0]           entry;
  logic [NcW-1:0]            n;
  logic [KW-1:0]             k;
  logic [NameW-1:0]          name_q;
  logic [NameW-1:0]          name_sh;
  logic [NameW-1:0]          name_in;
  logic [fdl_pkg::ByteW-1:0] cur;
  logic                      req_start;
  logic                      wr_en;
  logic [AddrW-1:0]          wr_addr;
  logic                      next_ok;

  assign name_in = NameW'(file_name);
  assign wr_en   = start && !busy && (command == fdl_pkg::CMD_LOAD) &&
                   (32'(byte_index) < 32'(DIR_BYTES));
  assign wr_addr = AddrW'(byte_index);
  assign next_ok = ((32'(k) + 32'd1) < 32'(ListBytes)) && (rdata != '0);

  assign chs_req.start    = req_start;
  assign chs_req.dividend = cur;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= byte_value;
    end
    rdata <= mem[ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      busy            <= 1'b0;
      result_valid    <= 1'b0;
      req_start       <= 1'b0;
      ptr             <= '0;
      base            <= '0;
      entry           <= '0;
      n               <= '0;
      k               <= '0;
      name_q          <= '0;
      name_sh         <= '0;
      cur             <= '0;
      status          <= fdl_pkg::ST_SECTOR;
      sector_number   <= '0;
      chunk_index     <= '0;
      track           <= '0;
      head            <= 1'b0;
      sector_in_track <= '0;
      last            <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      req_start    <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start && (command == fdl_pkg::CMD_LOOKUP)) begin
            busy    <= 1'b1;
            name_q  <= name_in;
            name_sh <= name_in;
            ptr     <= '0;
            base    <= '0;
            entry   <= '0;
            n       <= '0;
            state   <= S_SCAN_W;
          end
        end
        S_SCAN_W: begin
          state <= S_SCAN_C;
        end
        S_SCAN_C: begin
          if (rdata == name_sh[NameW-1 -: 8]) begin
            if (32'(n) == NAME_BYTES - 1) begin
              if (ListBytes == 0) begin
                result_valid    <= 1'b1;
                status          <= fdl_pkg::ST_EMPTY;
                sector_number   <= '0;
                chunk_index     <= '0;
                track           <= '0;
                head            <= 1'b0;
                sector_in_track <= '0;
                last            <= 1'b1;
                busy            <= 1'b0;
                state           <= S_IDLE;
              end else begin
                ptr   <= base + AddrW'(NAME_BYTES);
                k     <= '0;
                state <= S_LIST_W;
              end
            end else begin
              n       <= n + 1'b1;
              ptr     <= ptr + 1'b1;
              name_sh <= name_sh << 8;
              state   <= S_SCAN_W;
            end
          end else if (32'(entry) == NumEntries - 1) begin
            result_valid    <= 1'b1;
            status          <= fdl_pkg::ST_NOT_FOUND;
            sector_number   <= '0;
            chunk_index     <= '0;
            track           <= '0;
            head            <= 1'b0;
            sector_in_track <= '0;
            last            <= 1'b1;
            busy            <= 1'b0;
            state           <= S_IDLE;
          end else begin
            entry   <= entry + 1'b1;
            base    <= base + AddrW'(ENTRY_BYTES);
            ptr     <= base + AddrW'(ENTRY_BYTES);
            n       <= '0;
            name_sh <= name_q;
            state   <= S_SCAN_W;
          end
        end
        S_LIST_W: begin
          state <= S_LIST_C;
        end
        S_LIST_C: begin
          if (rdata == '0) begin
            result_valid    <= 1'b1;
            status          <= fdl_pkg::ST_EMPTY;
            sector_number   <= '0;
            chunk_index     <= '0;
            track           <= '0;
            head            <= 1'b0;
            sector_in_track <= '0;
            last            <= 1'b1;
            busy            <= 1'b0;
            state           <= S_IDLE;
          end else begin
            cur       <= rdata;
            req_start <= 1'b1;
            ptr       <= ptr + 1'b1;
            state     <= S_DIV;
          end
        end
        S_DIV: begin
          if (chs_rsp.done) begin
            result_valid    <= 1'b1;
            status          <= fdl_pkg::ST_SECTOR;
            sector_number   <= cur;
            chunk_index     <= fdl_pkg::ChunkW'(k);
            track           <= chs_rsp.track;
            head            <= chs_rsp.head;
            sector_in_track <= chs_rsp.sit;
            last            <= !next_ok;
            if (next_ok) begin
              k         <= k + 1'b1;
              cur       <= rdata;
              req_start <= 1'b1;
              ptr       <= ptr + 1'b1;
            end else begin
              busy  <= 1'b0;
              state <= S_IDLE;
            end
          end
        end
        default: begin
          busy  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> dv/fdl_sector_checker.sv
`timescale 1ns / 100ps
// Checker for file_directory_lookup_top: keeps a copy of the directory and the
// disk geometry, predicts the result words of each lookup and compares them
// with the result channel. Depends on fdl_pkg.
module fdl_sector_checker
  import fdl_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  logic                command,
  input  logic [IdxW-1:0]     byte_index,
  input  logic [ByteW-1:0]    byte_value,
  input  logic [NameInW-1:0]  file_name,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic                result_valid,
  input  logic [StatusW-1:0]  status,
  input  logic [ByteW-1:0]    sector_number,
  input  logic [ChunkW-1:0]   chunk_index,
  input  logic [ByteW-1:0]    track,
  input  logic                head,
  input  logic [SptW-1:0]     sector_in_track,
  input  logic                last,
  output int                  mismatches,
  output int                  words_due,
  output int                  words_checked
);

  localparam int EntryCount = DirBytesDef / EntryBytesDef;
  localparam int ListBytes  = EntryBytesDef - NameBytesDef;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [ByteW-1:0]   sector;
    logic [ChunkW-1:0]  chunk;
    logic [ByteW-1:0]   track;
    logic               head;
    logic [SptW-1:0]    sit;
    logic               last;
  } sector_word_t;

  logic [ByteW-1:0] dir_copy [DirBytesDef];
  logic [SptW-1:0]  spt_reg;
  logic [HcW-1:0]   hc_reg;
  sector_word_t     sectors_due [$];
  sector_word_t     seen;
  sector_word_t     want;
  int               fail_count = 0;
  int               checked = 0;

  function automatic string word_text(sector_word_t w);
    return $sformatf("status=%0d sector=%0d chunk=%0d track=%0d head=%0d sit=%0d last=%0d",
                     w.status, w.sector, w.chunk, w.track, w.head, w.sit, w.last);
  endfunction

  function automatic void predict_lookup(logic [NameInW-1:0] name);
    int base;
    int count;
    int spt;
    int hc;
    int s;
    bit hit;
    sector_word_t w;
    hit  = 0;
    base = 0;
    for (int e = 0; e < EntryCount && !hit; e++) begin
      base = e * EntryBytesDef;
      hit  = 1;
      for (int n = 0; n < NameBytesDef; n++) begin
        if (dir_copy[base + n] !== name[NameInW - 1 - 8 * n -: 8]) begin
          hit = 0;
          break;
        end
      end
    end
    w      = '0;
    w.last = 1'b1;
    if (!hit) begin
      w.status = ST_NOT_FOUND;
      sectors_due.push_back(w);
      return;
    end
    count = 0;
    while (count < ListBytes && dir_copy[base + NameBytesDef + count] != 0) count++;
    if (count == 0) begin
      w.status = ST_EMPTY;
      sectors_due.push_back(w);
      return;
    end
    // clamp out-of-range geometry
    spt = (spt_reg == 0) ? 1 : int'(spt_reg);
    hc  = (hc_reg == 0) ? 1 : ((hc_reg > 2) ? 2 : int'(hc_reg));
    for (int k = 0; k < count; k++) begin
      s        = int'(dir_copy[base + NameBytesDef + k]);
      w.status = ST_SECTOR;
      w.sector = ByteW'(s);
      w.chunk  = ChunkW'(k);
      w.track  = ByteW'(s / (spt * hc));
      w.head   = 1'((s / spt) % hc);
      w.sit    = SptW'((s % spt) + 1);
      w.last   = (k == count - 1);
      sectors_due.push_back(w);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      spt_reg = SPT_RESET;
      hc_reg  = HC_RESET;
      sectors_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_SPT) begin
          spt_reg = cfg_data[SptW-1:0];
        end else if (cfg_index == REG_HC) begin
          hc_reg = cfg_data[HcW-1:0];
        end
      end
      if (start && !busy) begin
        if (command == CMD_LOAD) begin
          if (int'(byte_index) < DirBytesDef) dir_copy[byte_index] = byte_value;
        end else begin
          predict_lookup(file_name);
        end
      end
      if (result_valid) begin
        seen = {status, sector_number, chunk_index, track, head, sector_in_track, last};
        if (sectors_due.size() == 0) begin
          fail_count++;
          $display("%0t: result word with none expected: %s", $time, word_text(seen));
        end else begin
          want = sectors_due.pop_front();
          checked++;
          if (seen !== want) begin
            fail_count++;
            $display("%0t: result word mismatch\n  expected %s\n  actual   %s",
                     $time, word_text(want), word_text(seen));
          end
        end
      end
    end
    mismatches    <= fail_count;
    words_due     <= sectors_due.size();
    words_checked <= checked;
  end

endmodule

>>> dv/file_directory_lookup_top_test.sv
`timescale 1ns / 100ps
// Testbench top for file_directory_lookup_top: fills the directory, drives
// directed and random lookups under several geometries and gives the verdict.
// Depends on fdl_pkg, the block and fdl_sector_checker.
module file_directory_lookup_top_test;
  import fdl_pkg::*;

  localparam int CycleLimit = 1000000;
  localparam int Settle     = 16;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic                command;
  logic [IdxW-1:0]     byte_index;
  logic [ByteW-1:0]    byte_value;
  logic [NameInW-1:0]  file_name;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  logic                result_valid;
  logic [StatusW-1:0]  status;
  logic [ByteW-1:0]    sector_number;
  logic [ChunkW-1:0]   chunk_index;
  logic [ByteW-1:0]    track;
  logic                head;
  logic [SptW-1:0]     sector_in_track;
  logic                last;
  int                  mismatches;
  int                  words_due;
  int                  words_checked;

  logic [ByteW-1:0] dir_img [DirBytesDef];
  bit               wrote [DirBytesDef];
  int               idle_pct = 0;
  int               load_count = 0;
  int               lookup_count = 0;
  int               cycles = 0;

  file_directory_lookup_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .byte_index(byte_index), .byte_value(byte_value), .file_name(file_name),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .result_valid(result_valid), .status(status),
    .sector_number(sector_number), .chunk_index(chunk_index), .track(track),
    .head(head), .sector_in_track(sector_in_track), .last(last)
  );

  fdl_sector_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .byte_index(byte_index), .byte_value(byte_value), .file_name(file_name),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .result_valid(result_valid), .status(status),
    .sector_number(sector_number), .chunk_index(chunk_index), .track(track),
    .head(head), .sector_in_track(sector_in_track), .last(last),
    .mismatches(mismatches), .words_due(words_due), .words_checked(words_checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic [NameInW-1:0] rand_name();
    return NameInW'({$urandom, $urandom});
  endfunction

  function automatic logic [NameInW-1:0] entry_name(int e);
    logic [NameInW-1:0] nm;
    for (int n = 0; n < NameBytesDef; n++)
      nm[NameInW - 1 - 8 * n -: 8] = dir_img[e * EntryBytesDef + n];
    return nm;
  endfunction

  // true when the sector walk of entry e stops before any unwritten byte
  function automatic bit list_covered(input int e);
    int b;
    b = e * EntryBytesDef + NameBytesDef;
    for (int k = 0; k < EntryBytesDef - NameBytesDef; k++) begin
      if (!wrote[b + k]) return 1'b0;
      if (dir_img[b + k] == '0) return 1'b1;
    end
    return 1'b1;
  endfunction

  task automatic push_word(input logic cmd, input logic [IdxW-1:0] idx,
                           input logic [ByteW-1:0] val, input logic [NameInW-1:0] nm);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start      <= 1'b1;
    command    <= cmd;
    byte_index <= idx;
    byte_value <= val;
    file_name  <= nm;
    do @(posedge clk); while (busy);
    if (cmd == CMD_LOAD) begin
      dir_img[idx] = val;
      wrote[idx]   = 1'b1;
      load_count++;
    end else begin
      lookup_count++;
    end
  endtask

  task automatic load_byte(input int idx, input int val);
    push_word(CMD_LOAD, IdxW'(idx), ByteW'(val), rand_name());
  endtask

  // write a zero instead when the walk would run into an unwritten byte
  task automatic safe_load(input int idx, input int val);
    logic [ByteW-1:0] keep;
    bit               kept;
    int               v;
    keep         = dir_img[idx];
    kept         = wrote[idx];
    v            = val;
    dir_img[idx] = ByteW'(val);
    wrote[idx]   = 1'b1;
    if (!list_covered(idx / EntryBytesDef)) v = 0;
    dir_img[idx] = keep;
    wrote[idx]   = kept;
    load_byte(idx, v);
  endtask

  task automatic lookup_name(input logic [NameInW-1:0] nm);
    push_word(CMD_LOOKUP, IdxW'($urandom_range(DirBytesDef - 1)),
              ByteW'($urandom_range(255)), nm);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // drop start, then wait for the block to drain every expected word
  task automatic settle();
    start <= 1'b0;
    repeat (2) @(posedge clk);
    while (words_due != 0 || busy) @(posedge clk);
    repeat (Settle) @(posedge clk);
  endtask

  task automatic plan_entry(input int e, input logic [NameInW-1:0] nm, input int len);
    int b;
    b = e * EntryBytesDef;
    for (int n = 0; n < NameBytesDef; n++) dir_img[b + n] = nm[NameInW - 1 - 8 * n -: 8];
    for (int k = 0; k < EntryBytesDef - NameBytesDef; k++) begin
      if (k < len) dir_img[b + NameBytesDef + k] = ByteW'($urandom_range(1, 255));
      else if (k == len) dir_img[b + NameBytesDef + k] = '0;
      else dir_img[b + NameBytesDef + k] = ByteW'($urandom_range(255));
    end
  endtask

  task automatic random_items(input int count);
    int r;
    int e;
    int pos;
    logic [NameInW-1:0] nm;
    repeat (count) begin
      r = $urandom_range(99);
      e = $urandom_range(DirBytesDef / EntryBytesDef - 1);
      if (r < 55) begin
        lookup_name(entry_name(e));
      end else if (r < 65) begin
        nm = entry_name(e);
        pos = $urandom_range(NameInW - 1);
        nm[pos] = ~nm[pos];
        lookup_name(nm);
      end else if (r < 68) begin
        lookup_name(rand_name());
      end else if (r < 88) begin
        safe_load(e * EntryBytesDef + NameBytesDef +
                  $urandom_range(EntryBytesDef - NameBytesDef - 1),
                  ($urandom_range(4) == 0) ? 0 : int'($urandom_range(1, 255)));
      end else if (r < 94) begin
        safe_load(e * EntryBytesDef + $urandom_range(NameBytesDef - 1),
                  $urandom_range(255));
      end else begin
        safe_load($urandom_range(DirBytesDef - 1), $urandom_range(255));
      end
    end
  endtask

  initial begin
    logic [CfgDataW-1:0] spt_set [6];
    logic [CfgDataW-1:0] hc_set [6];
    int idle_set [6];
    int b1;
    rst        = 1'b1;
    start      = 1'b0;
    command    = CMD_LOAD;
    byte_index = '0;
    byte_value = '0;
    file_name  = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    spt_set  = '{CfgDataW'(SPT_RESET), 8'd1, 8'd63, 8'hC0, 8'h40, 8'h49};
    hc_set   = '{CfgDataW'(HC_RESET), 8'd1, 8'd2, 8'hFF, 8'hFC, 8'h02};
    idle_set = '{0, 68, 0, 23, 68, 23};
    spt_set[4] = {2'($urandom), 6'($urandom_range(1, 63))};
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // lay out the directory, then load names and lists through the zero or last byte
    plan_entry(0, "README", 5);
    plan_entry(1, "KERNEL", EntryBytesDef - NameBytesDef);
    plan_entry(2, "EMPTY ", 0);
    plan_entry(3, "DUPLIC", 3);
    plan_entry(4, {NameInW{1'b1}}, 4);
    plan_entry(5, "DUPLIC", 7);
    plan_entry(6, '0, 2);
    for (int e = 7; e < DirBytesDef / EntryBytesDef; e++)
      plan_entry(e, rand_name(), $urandom_range(EntryBytesDef - NameBytesDef));
    b1 = EntryBytesDef + NameBytesDef;
    dir_img[b1]      = 8'd1;
    dir_img[b1 + 1]  = 8'd17;
    dir_img[b1 + 2]  = 8'd18;
    dir_img[b1 + 3]  = 8'd35;
    dir_img[b1 + 4]  = 8'd36;
    dir_img[b1 + 5]  = 8'd62;
    dir_img[b1 + 6]  = 8'd63;
    dir_img[b1 + 7]  = 8'd128;
    dir_img[b1 + 25] = 8'd255;
    for (int e = 0; e < DirBytesDef / EntryBytesDef; e++) begin
      for (int i = 0; i < EntryBytesDef; i++) begin
        load_byte(e * EntryBytesDef + i, int'(dir_img[e * EntryBytesDef + i]));
        if (i >= NameBytesDef && dir_img[e * EntryBytesDef + i] == '0) break;
      end
    end

    // directed lookups under the reset geometry
    for (int e = 0; e <= 6; e++) lookup_name(entry_name(e));
    lookup_name("NOFILE");
    lookup_name("READMF");
    lookup_name("SEADME");
    load_byte(2 * EntryBytesDef + NameBytesDef + 1, 0);
    load_byte(2 * EntryBytesDef + NameBytesDef, 200);
    lookup_name("EMPTY ");
    load_byte(2 * EntryBytesDef + NameBytesDef, 0);
    lookup_name("EMPTY ");
    load_byte(b1 + 12, 0);
    lookup_name("KERNEL");
    load_byte(b1 + 12, 255);
    lookup_name("KERNEL");
    random_items(32);

    for (int p = 1; p < 6; p++) begin
      settle();
      write_reg(REG_SPT, spt_set[p]);
      write_reg(REG_HC, hc_set[p]);
      if (p == 4) write_reg(4'hF, 8'hA5);
      cfg_valid <= 1'b0;
      idle_pct = idle_set[p];
      random_items(32);
    end
    settle();

    $display("Run covered %0d directory byte writes and %0d lookups over six geometries,",
             load_count, lookup_count);
    $display("with %0d result words checked and %0d mismatches.", words_checked, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/fdl_pkg.sv
rtl/fdl_chs.sv
rtl/fdl_seq.sv
rtl/file_directory_lookup_top.sv
dv/fdl_sector_checker.sv
dv/file_directory_lookup_top_test.sv
